// ===== rtl/core/kpq_pkg.sv =====
package kpq_pkg;

   localparam int DepthDefault = 16;

   localparam int ActionW = 3;
   localparam int PidW    = 15;
   localparam int WordW   = 16;
   localparam int StatusW = 3;
   localparam int CountW  = 5;

   typedef enum logic [ActionW-1:0] {
      ACT_ADD    = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_FIND   = 3'd2,
      ACT_PEEK   = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   typedef enum logic [StatusW-1:0] {
      STAT_OK        = 3'd0,
      STAT_DUP       = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   // One queue entry as it is held in a cell.
   typedef struct packed {
      logic [PidW-1:0]  pid;
      logic [WordW-1:0] burst;
      logic [WordW-1:0] mem_size;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic capture;   // latch the key compare for a new request
      logic load_new;  // store the entry being appended
      logic shift;     // take the neighbor's entry (compaction on remove)
   } cell_ctl_type;

endpackage

// ===== rtl/core/kpq_req_if.sv =====
interface kpq_req_if;
   logic                        valid;
   logic                        ready;
   logic [kpq_pkg::ActionW-1:0] action;
   logic [kpq_pkg::PidW-1:0]    pid;
   logic [kpq_pkg::WordW-1:0]   burst;
   logic [kpq_pkg::WordW-1:0]   mem_size;

   modport source (output valid, action, pid, burst, mem_size, input ready);
   modport sink   (input valid, action, pid, burst, mem_size, output ready);
endinterface

// ===== rtl/core/kpq_rsp_if.sv =====
interface kpq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kpq_pkg::StatusW-1:0] status;
   logic [kpq_pkg::PidW-1:0]    out_pid;
   logic [kpq_pkg::WordW-1:0]   out_burst;
   logic [kpq_pkg::WordW-1:0]   out_mem_size;
   logic [kpq_pkg::CountW-1:0]  count;

   modport source (output valid, status, out_pid, out_burst, out_mem_size, count,
                   input ready);
   modport sink   (input valid, status, out_pid, out_burst, out_mem_size, count,
                   output ready);
endinterface

// ===== rtl/core/keyed_process_queue.sv =====
// Ordered process queue with removal by process id.
// A request on req_chan carries an action (add, remove, find, peek, clear),
// a process id and, for an add, the burst length and memory size to store.
// Every request gives exactly one response on rsp_chan: a status, the entry
// returned by remove, find or peek (zero otherwise) and the entry count
// after the request. Both channels use a valid/ready handshake.
// In the accept cycle of a request every cell compares its stored id
// with the key, and in the following cycle the sequencer resolves the
// hit, updates the cells (append, one-step compaction or clear) and loads
// the response register, which drives the response. A new request is only
// taken once the previous one is resolved. The response register lets the
// next request be accepted while the previous response still waits; if the
// receiver stalls longer, the sequencer holds its resolve state and leaves
// the queue unchanged until the response register frees up.
// Reset empties the queue and drops any pending response. Slot contents
// are not cleared; a slot is only read once it holds a queued entry.
module keyed_process_queue #(
   parameter int DEPTH = kpq_pkg::DepthDefault
) (
   input logic        clock,
   input logic        reset,
   kpq_req_if.sink    req_chan,
   kpq_rsp_if.source  rsp_chan
);

   localparam int CntW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic [kpq_pkg::ActionW-1:0] action;
      kpq_pkg::entry_type          entry;
   } req_type;

   typedef struct packed {
      logic [kpq_pkg::StatusW-1:0] status;
      kpq_pkg::entry_type          entry;
      logic [kpq_pkg::CountW-1:0]  count;
   } rsp_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic req_fire;
   logic exec_fire;

   kpq_pkg::entry_type   cell_entry [DEPTH];
   kpq_pkg::cell_ctl_type cell_ctl [DEPTH];
   logic [DEPTH-1:0]     match_vec;
   logic [DEPTH-1:0]     valid_vec;
   logic [DEPTH-1:0]     prefix_vec;

   logic               hit;
   logic               empty;
   logic               full;
   logic               do_add;
   logic               do_remove;
   kpq_pkg::entry_type found_entry;
   logic [CntW+kpq_pkg::CountW-1:0] cnt_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign exec_fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // The row of cells. Cell 0 is the head of the queue.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [DEPTH-1:0] LowMask = {DEPTH{1'b1}} >> (DEPTH - 1 - i);
      kpq_pkg::entry_type next_entry;

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      assign valid_vec[i]  = CntW'(i) < cnt_ff;
      // Ids are unique in the queue, so every cell at or after the hit closes up.
      assign prefix_vec[i] = |(match_vec & LowMask);

      assign cell_ctl[i].capture  = req_fire;
      assign cell_ctl[i].load_new = do_add && (cnt_ff == CntW'(i));
      assign cell_ctl[i].shift    = do_remove && prefix_vec[i];

      kpq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .slot_valid (valid_vec[i]),
         .key        (req_chan.pid),
         .new_entry  (req_ff.entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .match      (match_vec[i])
      );
   end

   // At most one cell matches, so an AND-OR mux picks the hit entry.
   always_comb begin
      found_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_entry = kpq_pkg::entry_type'(found_entry |
                       (cell_entry[i] & {kpq_pkg::EntryW{match_vec[i]}}));
      end
   end

   assign hit   = |match_vec;
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CntW'(DEPTH));

   assign do_add    = exec_fire && (req_ff.action == kpq_pkg::ACT_ADD) && !hit && !full;
   assign do_remove = exec_fire && (req_ff.action == kpq_pkg::ACT_REMOVE) && !empty && hit;

   // Resolve the request and build the response.
   always_comb begin
      cnt_in               = cnt_ff;
      rsp_in.status        = kpq_pkg::STAT_OK;
      rsp_in.entry         = '0;
      case (req_ff.action) inside
         kpq_pkg::ACT_ADD: begin
            if (hit) begin
               rsp_in.status = kpq_pkg::STAT_DUP;
            end else if (full) begin
               rsp_in.status = kpq_pkg::STAT_FULL;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         kpq_pkg::ACT_REMOVE, kpq_pkg::ACT_FIND: begin
            if (empty) begin
               rsp_in.status = kpq_pkg::STAT_EMPTY;
            end else if (!hit) begin
               rsp_in.status = kpq_pkg::STAT_NOT_FOUND;
            end else begin
               rsp_in.entry = found_entry;
               if (req_ff.action == kpq_pkg::ACT_REMOVE) begin
                  cnt_in = cnt_ff - CntW'(1);
               end
            end
         end
         kpq_pkg::ACT_PEEK: begin
            if (empty) begin
               rsp_in.status = kpq_pkg::STAT_EMPTY;
            end else begin
               rsp_in.entry = cell_entry[0];
            end
         end
         kpq_pkg::ACT_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            // Unknown actions leave the queue alone and report success.
         end
      endcase
      // The count field is five bits wide and wraps for deep queues.
      cnt_ext      = {{kpq_pkg::CountW{1'b0}}, cnt_in};
      rsp_in.count = cnt_ext[kpq_pkg::CountW-1:0];
   end

   // Sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.action         <= req_chan.action;
         req_ff.entry.pid      <= req_chan.pid;
         req_ff.entry.burst    <= req_chan.burst;
         req_ff.entry.mem_size <= req_chan.mem_size;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.out_pid      = rsp_ff.entry.pid;
   assign rsp_chan.out_burst    = rsp_ff.entry.burst;
   assign rsp_chan.out_mem_size = rsp_ff.entry.mem_size;
   assign rsp_chan.count        = rsp_ff.count;

   // The queue never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(DEPTH))
      else $error("entry count exceeds queue depth");

   // Ids are unique, so a key hits at most one cell.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(match_vec))
      else $error("key matched more than one cell");

   // An accepted request enters its resolve state in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter its resolve cycle");

   // A response only appears at the end of a resolve cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside a resolve cycle");

endmodule

// ===== rtl/core/kpq_cell.sv =====
// One queue slot: holds an entry, compares it against the request key and
// takes its right-hand neighbor's entry when the queue closes a gap.
module kpq_cell (
   input  logic                     clock,
   input  kpq_pkg::cell_ctl_type    ctl,
   input  logic                     slot_valid,
   input  logic [kpq_pkg::PidW-1:0] key,
   input  kpq_pkg::entry_type       new_entry,
   input  kpq_pkg::entry_type       next_entry,
   output kpq_pkg::entry_type       entry,
   output logic                     match
);

   kpq_pkg::entry_type entry_ff;
   logic               match_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         match_ff <= slot_valid && (entry_ff.pid == key);
      end
      if (ctl.load_new) begin
         entry_ff <= new_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== bench/tb_keyed_process_queue.sv =====
`timescale 1ns / 100ps

module tb_keyed_process_queue;

   localparam int QDepth = kpq_pkg::DepthDefault;

   // One request as the sender offers it. The drain_first flag makes the
   // sender wait until every outstanding response has come back before it
   // offers this request.
   typedef struct {
      logic [kpq_pkg::ActionW-1:0] action;
      logic [kpq_pkg::PidW-1:0]    pid;
      logic [kpq_pkg::WordW-1:0]   burst;
      logic [kpq_pkg::WordW-1:0]   mem_size;
      bit                          drain_first;
   } proc_request_type;

   // One response, field by field, as the result channel carries it.
   typedef struct {
      logic [kpq_pkg::StatusW-1:0] status;
      logic [kpq_pkg::PidW-1:0]    out_pid;
      logic [kpq_pkg::WordW-1:0]   out_burst;
      logic [kpq_pkg::WordW-1:0]   out_mem_size;
      logic [kpq_pkg::CountW-1:0]  count;
   } proc_response_type;

   logic clock = 1'b0;
   logic reset;

   kpq_req_if req_bus ();
   kpq_rsp_if rsp_bus ();

   keyed_process_queue #(
      .DEPTH(QDepth)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered, the queue contents as the block should
   // hold them, and the responses that are owed for accepted requests.
   proc_request_type   pending_requests[$];
   kpq_pkg::entry_type queue_entries[$];
   proc_response_type  owed_responses[$];

   // The driver bumps requests_sent at once; the monitor updates
   // responses_seen with a nonblocking assignment, so other processes that
   // compare the two always see the value from before the clock edge.
   int unsigned requests_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned mismatches = 0;
   int unsigned holdoff_left = 0;
   int unsigned next_holdoff_at = 600;

   // Applies one request to the expected queue contents and returns the
   // response the block must give for it. The key search covers only the
   // entries held, so slots that were never written are never looked at.
   task automatic apply_request(input proc_request_type rq, output proc_response_type rs);
      int hit;
      hit = -1;
      rs = '{default: '0};
      for (int i = 0; i < queue_entries.size(); i++) begin
         if (hit < 0 && queue_entries[i].pid == rq.pid) begin
            hit = i;
         end
      end
      case (rq.action)
         kpq_pkg::ACT_ADD: begin
            // The duplicate check comes first, so a duplicate on a full
            // queue reports a duplicate rather than a full queue.
            if (hit >= 0) begin
               rs.status = kpq_pkg::STAT_DUP;
            end else if (queue_entries.size() >= QDepth) begin
               rs.status = kpq_pkg::STAT_FULL;
            end else begin
               queue_entries.push_back('{pid: rq.pid, burst: rq.burst,
                                         mem_size: rq.mem_size});
               rs.status = kpq_pkg::STAT_OK;
            end
         end
         kpq_pkg::ACT_REMOVE, kpq_pkg::ACT_FIND: begin
            if (queue_entries.size() == 0) begin
               rs.status = kpq_pkg::STAT_EMPTY;
            end else if (hit < 0) begin
               rs.status = kpq_pkg::STAT_NOT_FOUND;
            end else begin
               rs.status       = kpq_pkg::STAT_OK;
               rs.out_pid      = queue_entries[hit].pid;
               rs.out_burst    = queue_entries[hit].burst;
               rs.out_mem_size = queue_entries[hit].mem_size;
               // A remove closes the gap and keeps the order of the rest.
               if (rq.action == kpq_pkg::ACT_REMOVE) begin
                  queue_entries.delete(hit);
               end
            end
         end
         kpq_pkg::ACT_PEEK: begin
            if (queue_entries.size() == 0) begin
               rs.status = kpq_pkg::STAT_EMPTY;
            end else begin
               rs.status       = kpq_pkg::STAT_OK;
               rs.out_pid      = queue_entries[0].pid;
               rs.out_burst    = queue_entries[0].burst;
               rs.out_mem_size = queue_entries[0].mem_size;
            end
         end
         kpq_pkg::ACT_CLEAR: begin
            queue_entries.delete();
            rs.status = kpq_pkg::STAT_OK;
         end
         default: begin
            // Unknown actions leave the queue alone and report success.
            rs.status = kpq_pkg::STAT_OK;
         end
      endcase
      rs.count = kpq_pkg::CountW'(queue_entries.size());
   endtask

   function automatic void queue_request(input logic [kpq_pkg::ActionW-1:0] act,
                                         input logic [kpq_pkg::PidW-1:0] id,
                                         input logic [kpq_pkg::WordW-1:0] bl,
                                         input logic [kpq_pkg::WordW-1:0] ms,
                                         input bit drain);
      proc_request_type rq;
      rq.action      = act;
      rq.pid         = id;
      rq.burst       = bl;
      rq.mem_size    = ms;
      rq.drain_first = drain;
      pending_requests.push_back(rq);
   endfunction

   // Sender. It works in bursts of random length separated by random gaps.
   // A request that is offered stays on the bus, unchanged, until the block
   // takes it. Every acceptance is predicted on the spot, so the owed
   // response is queued one timestep or more before it can come back.
   always @(posedge clock) begin : sender
      proc_response_type rs;
      proc_request_type  nxt;
      int unsigned       gap_left;
      int unsigned       burst_left;
      bit                took;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
      end else begin
         took = req_bus.valid && req_bus.ready;
         if (took) begin
            nxt = pending_requests.pop_front();
            apply_request(nxt, rs);
            owed_responses.push_back(rs);
            requests_sent++;
         end
         if (req_bus.valid && !took) begin
            // Still waiting for the block to take the request on offer.
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain_first &&
                       requests_sent != responses_seen)) begin
            req_bus.valid <= 1'b0;
         end else begin
            nxt = pending_requests[0];
            req_bus.valid    <= 1'b1;
            req_bus.action   <= nxt.action;
            req_bus.pid      <= nxt.pid;
            req_bus.burst    <= nxt.burst;
            req_bus.mem_size <= nxt.mem_size;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // A quarter of the bursts run straight into the next one,
               // which gives long stretches with no idle cycles at all.
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end
      end
   end

   // Long receiver hold-offs. Twice during the run the receiver drops ready
   // for a long hold-off while the sender keeps offering requests, so
   // the block fills up and must stall its input.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (responses_seen >= next_holdoff_at) begin
         holdoff_left    <= $urandom_range(250, 400);
         next_holdoff_at <= next_holdoff_at + 800;
      end
   end

   // Receiver. Each accepted response is checked against the oldest owed
   // one. The stall pattern is drawn anew at regular intervals from always ready,
   // mostly ready, a fixed one-in-three rhythm and mostly stalled.
   always @(posedge clock) begin : receiver
      proc_response_type want;
      int unsigned       cycle_no;
      int unsigned       stall_mode;
      bit                bad;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         cycle_no   = 0;
         stall_mode = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_seen <= responses_seen + 1;
            if (owed_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response with nothing owed: status %0d pid %0h count %0d",
                           $realtime, rsp_bus.status, rsp_bus.out_pid, rsp_bus.count);
               end
            end else begin
               want = owed_responses.pop_front();
               bad = (rsp_bus.status !== want.status) ||
                     (rsp_bus.out_pid !== want.out_pid) ||
                     (rsp_bus.out_burst !== want.out_burst) ||
                     (rsp_bus.out_mem_size !== want.out_mem_size) ||
                     (rsp_bus.count !== want.count);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected status %0d pid %0h burst %0h mem %0h count %0d",
                              $realtime, want.status, want.out_pid, want.out_burst,
                              want.out_mem_size, want.count);
                     $display("%0t: actual   status %0d pid %0h burst %0h mem %0h count %0d",
                              $realtime, rsp_bus.status, rsp_bus.out_pid,
                              rsp_bus.out_burst, rsp_bus.out_mem_size, rsp_bus.count);
                  end
               end
            end
         end
         cycle_no++;
         if (cycle_no % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0:       rsp_bus.ready <= (holdoff_left == 0);
            1:       rsp_bus.ready <= (holdoff_left == 0) && ($urandom_range(0, 3) != 0);
            2:       rsp_bus.ready <= (holdoff_left == 0) && (cycle_no % 3 == 0);
            default: rsp_bus.ready <= (holdoff_left == 0) && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [kpq_pkg::PidW-1:0]    id_pool[24];
      int unsigned                 pool_size;
      int unsigned                 add_pct;
      int unsigned                 phase_len;
      int unsigned                 made;
      int unsigned                 roll;
      logic [kpq_pkg::ActionW-1:0] act;
      logic [kpq_pkg::PidW-1:0]    id;

      reset = 1'b1;

      // Directed part. Peek, remove and find on an empty queue all report an
      // empty queue; unknown actions do nothing and report success.
      queue_request(kpq_pkg::ACT_PEEK, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_REMOVE, 15'h0005, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_FIND, 15'h0005, 16'h0000, 16'h0000, 1'b0);
      queue_request(3'd5, 15'h7fff, 16'hffff, 16'hffff, 1'b0);
      queue_request(3'd7, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      // Extreme field values, a duplicate, a hit and a miss.
      queue_request(kpq_pkg::ACT_ADD, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_ADD, 15'h7fff, 16'hffff, 16'hffff, 1'b0);
      queue_request(kpq_pkg::ACT_ADD, 15'h0000, 16'h1234, 16'h5678, 1'b0);
      queue_request(kpq_pkg::ACT_FIND, 15'h7fff, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_FIND, 15'h1234, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_REMOVE, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_REMOVE, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_PEEK, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      // Fill the queue to the top, then try an add on a full queue and a
      // duplicate on a full queue, which must report the duplicate.
      for (int i = 1; i < QDepth; i++) begin
         queue_request(kpq_pkg::ACT_ADD, kpq_pkg::PidW'(i * 16'h0911),
                       kpq_pkg::WordW'(i * 16'h1111),
                       kpq_pkg::WordW'(~(i * 16'h1111)), 1'b0);
      end
      queue_request(kpq_pkg::ACT_ADD, 15'h5555, 16'haaaa, 16'h5555, 1'b0);
      queue_request(kpq_pkg::ACT_ADD, 15'h7fff, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_REMOVE, kpq_pkg::PidW'(8 * 16'h0911), 16'h0000, 16'h0000,
                    1'b0);
      queue_request(kpq_pkg::ACT_PEEK, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(kpq_pkg::ACT_CLEAR, 15'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_request(3'd6, 15'h2aaa, 16'h5555, 16'haaaa, 1'b0);
      queue_request(kpq_pkg::ACT_FIND, 15'h7fff, 16'h0000, 16'h0000, 1'b0);

      // Random part in phases. Each phase draws ids from a small pool so
      // adds collide and removes and finds hit, and its own add share
      // pushes the queue toward full or toward empty. A few requests per
      // phase use a fully random id or an unknown action as noise. The
      // first request of every phase waits until the block has drained.
      made = 0;
      while (made < 2000) begin
         pool_size = $urandom_range(2, 24);
         for (int i = 0; i < pool_size; i++) begin
            id_pool[i] = kpq_pkg::PidW'($urandom_range(0, 32767));
         end
         if ($urandom_range(0, 3) == 0) begin
            id_pool[0] = '0;
            id_pool[1] = '1;
         end
         add_pct   = $urandom_range(20, 75);
         phase_len = $urandom_range(40, 150);
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
               act = kpq_pkg::ACT_ADD;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 42) begin
                  act = kpq_pkg::ACT_REMOVE;
               end else if (roll < 80) begin
                  act = kpq_pkg::ACT_FIND;
               end else if (roll < 93) begin
                  act = kpq_pkg::ACT_PEEK;
               end else if (roll < 97) begin
                  act = kpq_pkg::ACT_CLEAR;
               end else begin
                  act = kpq_pkg::ActionW'($urandom_range(5, 7));
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               id = kpq_pkg::PidW'($urandom_range(0, 32767));
            end else begin
               id = id_pool[$urandom_range(0, pool_size - 1)];
            end
            queue_request(act, id, kpq_pkg::WordW'($urandom_range(0, 65535)),
                          kpq_pkg::WordW'($urandom_range(0, 65535)), n == 0);
            made++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait on the falling edge, where every counter and queue is settled,
      // until all requests are taken and every owed response has come.
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_bus.valid ||
                 requests_sent != responses_seen);
      repeat (20) @(negedge clock);
      mismatches += owed_responses.size();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
